// ===== rtl/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, register codes and the character-to-pattern table of the
// Morse character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    // Widest pattern in the table (digits carry five elements)
    localparam int MCK_MAX_ELEMENTS = 5;
    localparam int MCK_ELEM_CNT_W   = $clog2(MCK_MAX_ELEMENTS + 1);
    localparam int MCK_DUR_W        = 4;
    localparam int MCK_CODE_W       = 8;
    localparam int MCK_CFG_ADDR_W   = 3;
    localparam int MCK_QUEUE_DEPTH  = 2;
    // Interval counter covers 2 * elements + 1 intervals
    localparam int MCK_STEP_W       = $clog2(2 * MCK_MAX_ELEMENTS + 1);
    localparam int MCK_OUT_DATA_W   = 8;

    // Character byte boundaries
    localparam logic [MCK_CODE_W-1:0] RAW_MAX     = 8'h0F;
    localparam logic [MCK_CODE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [MCK_CODE_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [MCK_CODE_W-1:0] UPPER_A     = 8'h41;
    localparam logic [MCK_CODE_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [MCK_CODE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [MCK_CODE_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [MCK_CODE_W-1:0] LETTER_BASE = 8'd10;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    // Register indexes
    typedef enum logic [MCK_CFG_ADDR_W-1:0] {
        REG_DIT        = 3'd0,
        REG_DAH        = 3'd1,
        REG_ELEM_GAP   = 3'd2,
        REG_CHAR_SPACE = 3'd3,
        REG_WORD_SPACE = 3'd4
    } cfg_idx_t;

    // Register file contents
    typedef struct packed {
        logic [MCK_DUR_W-1:0] dit;
        logic [MCK_DUR_W-1:0] dah;
        logic [MCK_DUR_W-1:0] elem_gap;
        logic [MCK_DUR_W-1:0] char_space;
        logic [MCK_DUR_W-1:0] word_gap;
    } cfg_t;

    // Pattern: bit i is element i, 1 = dah
    typedef struct packed {
        logic                        hit;
        logic [MCK_ELEM_CNT_W-1:0]   n_elem;
        logic [MCK_MAX_ELEMENTS-1:0] pat;
    } lookup_t;

    // Queue entry between front and back
    typedef struct packed {
        logic                        word;
        logic [MCK_ELEM_CNT_W-1:0]   n_elem;
        logic [MCK_MAX_ELEMENTS-1:0] pat;
    } cmd_t;

    // Map a byte to its pattern; hit is low for unmapped bytes
    function automatic lookup_t morse_lookup(input logic [MCK_CODE_W-1:0] code);
        lookup_t               r;
        logic [MCK_CODE_W-1:0] idx;
        r   = '0;
        idx = '0;
        if (code <= RAW_MAX) begin
            idx   = code;
            r.hit = 1'b1;
        end else if (code >= ASCII_ZERO && code <= ASCII_NINE) begin
            idx   = code - ASCII_ZERO;
            r.hit = 1'b1;
        end else if (code >= UPPER_A && code <= UPPER_Z) begin
            idx   = code - UPPER_A + LETTER_BASE;
            r.hit = 1'b1;
        end else if (code >= LOWER_A && code <= LOWER_Z) begin
            idx   = code - LOWER_A + LETTER_BASE;
            r.hit = 1'b1;
        end
        case (idx[5:0])
            6'd0:  {r.n_elem, r.pat} = {3'd5, 5'b11111};
            6'd1:  {r.n_elem, r.pat} = {3'd5, 5'b11110};
            6'd2:  {r.n_elem, r.pat} = {3'd5, 5'b11100};
            6'd3:  {r.n_elem, r.pat} = {3'd5, 5'b11000};
            6'd4:  {r.n_elem, r.pat} = {3'd5, 5'b10000};
            6'd5:  {r.n_elem, r.pat} = {3'd5, 5'b00000};
            6'd6:  {r.n_elem, r.pat} = {3'd5, 5'b00001};
            6'd7:  {r.n_elem, r.pat} = {3'd5, 5'b00011};
            6'd8:  {r.n_elem, r.pat} = {3'd5, 5'b00111};
            6'd9:  {r.n_elem, r.pat} = {3'd5, 5'b01111};
            6'd10: {r.n_elem, r.pat} = {3'd2, 5'b00010}; // A
            6'd11: {r.n_elem, r.pat} = {3'd4, 5'b00001}; // B
            6'd12: {r.n_elem, r.pat} = {3'd4, 5'b00101}; // C
            6'd13: {r.n_elem, r.pat} = {3'd3, 5'b00001}; // D
            6'd14: {r.n_elem, r.pat} = {3'd1, 5'b00000}; // E
            6'd15: {r.n_elem, r.pat} = {3'd4, 5'b00100}; // F
            6'd16: {r.n_elem, r.pat} = {3'd3, 5'b00011}; // G
            6'd17: {r.n_elem, r.pat} = {3'd4, 5'b00000}; // H
            6'd18: {r.n_elem, r.pat} = {3'd2, 5'b00000}; // I
            6'd19: {r.n_elem, r.pat} = {3'd4, 5'b01110}; // J
            6'd20: {r.n_elem, r.pat} = {3'd3, 5'b00101}; // K
            6'd21: {r.n_elem, r.pat} = {3'd4, 5'b00010}; // L
            6'd22: {r.n_elem, r.pat} = {3'd2, 5'b00011}; // M
            6'd23: {r.n_elem, r.pat} = {3'd2, 5'b00001}; // N
            6'd24: {r.n_elem, r.pat} = {3'd3, 5'b00111}; // O
            6'd25: {r.n_elem, r.pat} = {3'd4, 5'b00110}; // P
            6'd26: {r.n_elem, r.pat} = {3'd4, 5'b01011}; // Q
            6'd27: {r.n_elem, r.pat} = {3'd3, 5'b00010}; // R
            6'd28: {r.n_elem, r.pat} = {3'd3, 5'b00000}; // S
            6'd29: {r.n_elem, r.pat} = {3'd1, 5'b00001}; // T
            6'd30: {r.n_elem, r.pat} = {3'd3, 5'b00100}; // U
            6'd31: {r.n_elem, r.pat} = {3'd4, 5'b01000}; // V
            6'd32: {r.n_elem, r.pat} = {3'd3, 5'b00110}; // W
            6'd33: {r.n_elem, r.pat} = {3'd4, 5'b01001}; // X
            6'd34: {r.n_elem, r.pat} = {3'd4, 5'b01101}; // Y
            6'd35: {r.n_elem, r.pat} = {3'd4, 5'b00011}; // Z
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mck_front.sv =====
// ----------------------------------------------------------------------------
// mck_front
// Input side: takes request beats, maps characters to their patterns and
// pushes one command per mapped character or word space. Unmapped bytes
// are consumed and dropped.
// ----------------------------------------------------------------------------
module mck_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mck_pkg::MCK_CODE_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                          s_tuser,   // [0] kind
    input  logic                          q_full,
    output logic                          q_push,
    output mck_pkg::cmd_t                 q_wdata
);
    import mck_pkg::*;

    lookup_t lk;

    // Table lookup on the incoming byte
    assign lk = morse_lookup(s_tdata);

    assign s_tready = !q_full;

    // Build the command
    always_comb begin
        q_wdata        = '0;
        q_wdata.word   = (s_tuser == KIND_WORD);
        q_wdata.n_elem = lk.n_elem;
        q_wdata.pat    = lk.pat;
    end

    // Only word spaces and mapped characters make it into the queue
    assign q_push = s_tvalid && s_tready && ((s_tuser == KIND_WORD) || lk.hit);

endmodule

// ===== rtl/mck_queue.sv =====
// ----------------------------------------------------------------------------
// mck_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mck_queue #(
    parameter int DEPTH = mck_pkg::MCK_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mck_pkg::cmd_t wdata,
    input  logic          pop,
    output mck_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);
    import mck_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/mck_back.sv =====
// ----------------------------------------------------------------------------
// mck_back
// Output side: takes one command at a time from the queue and steps through
// its keying intervals, one beat per cycle into the output register while not stalled.
// ----------------------------------------------------------------------------
module mck_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mck_pkg::cfg_t                      cfg,
    input  logic                               q_empty,
    input  mck_pkg::cmd_t                      q_rdata,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mck_pkg::MCK_OUT_DATA_W-1:0] m_tdata,  // [0] key_on, [4:1] duration
    output logic                               m_tlast   // last
);
    import mck_pkg::*;

    logic                      active_reg, active_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [MCK_STEP_W-1:0]     step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_key_reg, out_key_next;
    logic [MCK_DUR_W-1:0]      out_dur_reg, out_dur_next;
    logic                      out_last_reg, out_last_next;

    logic                      advance;
    logic [MCK_STEP_W-1:0]     char_end;
    logic [MCK_STEP_W-2:0]     elem_idx;
    logic                      is_dah;
    logic                      iv_key;
    logic [MCK_DUR_W-1:0]      iv_dur;
    logic                      iv_last;

    assign advance  = !out_valid_reg || m_tready;
    assign q_pop    = !active_reg && !q_empty;
    assign char_end = {cmd_reg.n_elem, 1'b0};
    assign elem_idx = step_reg[MCK_STEP_W-1:1];
    assign is_dah   = (elem_idx < (MCK_STEP_W-1)'(MCK_MAX_ELEMENTS)) ?
                      cmd_reg.pat[elem_idx] : 1'b0;

    // Current interval: element, gap after it, or the closing space
    always_comb begin
        iv_key  = 1'b0;
        iv_dur  = cfg.elem_gap;
        iv_last = 1'b0;
        if (cmd_reg.word) begin
            iv_dur  = cfg.word_gap;
            iv_last = 1'b1;
        end else if (step_reg == char_end) begin
            iv_dur  = cfg.char_space;
            iv_last = 1'b1;
        end else if (!step_reg[0]) begin
            iv_key = 1'b1;
            iv_dur = is_dah ? cfg.dah : cfg.dit;
        end
    end

    // Sequencer and output register
    always_comb begin
        active_next    = active_reg;
        cmd_next       = cmd_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_dur_next   = out_dur_reg;
        out_last_next  = out_last_reg;
        if (q_pop) begin
            active_next = 1'b1;
            cmd_next    = q_rdata;
            step_next   = '0;
        end
        if (advance) begin
            out_valid_next = active_reg;
            if (active_reg) begin
                out_key_next  = iv_key;
                out_dur_next  = iv_dur;
                out_last_next = iv_last;
                step_next     = step_reg + 1'b1;
                if (iv_last) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        step_reg     <= step_next;
        out_key_reg  <= out_key_next;
        out_dur_reg  <= out_dur_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MCK_OUT_DATA_W'({out_dur_reg, out_key_reg});
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/morse_character_keyer.sv =====
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns characters and word-space requests into Morse keying intervals.
//
//   channel | dir | fields (low bit up)
//   --------+-----+---------------------------------------------------
//   s_      | in  | tdata: char_code[7:0]; tuser: kind
//   m_      | out | tdata: key_on, duration[4:1]; tlast: last
//   cfg_    | in  | wr_en, addr[2:0] register index, wdata[3:0]
//
// The back end emits one interval per cycle while the output is not stalled; it loads
// a command, then 2n+1 intervals for a character of n elements, one for a word space.
// The front end takes a new beat every cycle while the two-entry queue has
// room, so input and output stall independently.
// Reset is synchronous, active low; it restores the default timing registers.
// ----------------------------------------------------------------------------
module morse_character_keyer #(
    parameter int QUEUE_DEPTH = mck_pkg::MCK_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mck_pkg::MCK_CODE_W-1:0]      s_tdata,   // [7:0] char_code
    input  logic                                s_tuser,   // [0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mck_pkg::MCK_OUT_DATA_W-1:0]  m_tdata,   // [0] key_on, [4:1] duration
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [mck_pkg::MCK_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mck_pkg::MCK_DUR_W-1:0]       cfg_wdata
);
    import mck_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_wdata, q_rdata;

    // Timing registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DIT:        cfg_next.dit        = cfg_wdata;
                REG_DAH:        cfg_next.dah        = cfg_wdata;
                REG_ELEM_GAP:   cfg_next.elem_gap   = cfg_wdata;
                REG_CHAR_SPACE: cfg_next.char_space = cfg_wdata;
                REG_WORD_SPACE: cfg_next.word_gap   = cfg_wdata;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dit        <= 4'd1;
            cfg_reg.dah        <= 4'd3;
            cfg_reg.elem_gap   <= 4'd1;
            cfg_reg.char_space <= 4'd3;
            cfg_reg.word_gap   <= 4'd7;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mck_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    mck_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // A key-on interval never closes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tlast)
        else $error("key-on beat marked last");

    // Every element taken is followed directly by its key-off gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[0] |=> m_tvalid && !m_tdata[0])
        else $error("element not followed by gap");

    // The back end only pops when the queue holds a command
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // A refused input beat means the queue is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_full && !q_empty)
        else $error("input stalled with room in queue");
`endif

endmodule

// ===== verif/tb_morse_character_keyer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_character_keyer
// Self-checking bench for the Morse character keyer. A directed table covers
// the edges of the character map, both item kinds and unmapped bytes. Random
// characters and word spaces then run under several timing settings and
// several mixes of stalls on the input and output streams. Every interval
// beat is checked against an in-bench model of the keying rules.
// ----------------------------------------------------------------------------
module tb_morse_character_keyer;
    import mck_pkg::*;

    // One keying interval as seen on the output stream
    typedef struct packed {
        logic                 key_on;
        logic [MCK_DUR_W-1:0] duration;
        logic                 last;
    } interval_t;

    // Directed row; typed rows carry their intervals, others go to the model
    typedef struct packed {
        logic                  kind;
        logic [MCK_CODE_W-1:0] code;
        logic                  typed;
        logic [1:0]            n_typed;
        interval_t [0:2]       typed_iv;
    } stim_row_t;

    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;

    // Indexes past the register file; writes there must be dropped
    localparam logic [MCK_CFG_ADDR_W-1:0] STRAY_IDX_A = 3'd5;
    localparam logic [MCK_CFG_ADDR_W-1:0] STRAY_IDX_B = 3'd7;

    // Patterns with a leading marker bit; below it, first element first,
    // 1 = dah, 0 = dit
    localparam logic [5:0] MORSE_SYMBOLS [36] = '{
        6'b111111, 6'b101111, 6'b100111, 6'b100011, 6'b100001,   // 0-4
        6'b100000, 6'b110000, 6'b111000, 6'b111100, 6'b111110,   // 5-9
        6'b000101, 6'b011000, 6'b011010, 6'b001100, 6'b000010,   // A-E
        6'b010010, 6'b001110, 6'b010000, 6'b000100, 6'b010111,   // F-J
        6'b001101, 6'b010100, 6'b000111, 6'b000110, 6'b001111,   // K-O
        6'b010110, 6'b011101, 6'b001010, 6'b001000, 6'b000011,   // P-T
        6'b001001, 6'b010001, 6'b001011, 6'b011001, 6'b011011,   // U-Y
        6'b011100                                                // Z
    };

    // Directed items, all sent with the timing at its reset values
    localparam stim_row_t DIRECTED_ROWS [24] = '{
        '{KIND_WORD, 8'h00, 1'b1, 2'd1, '{'{1'b0, 4'd7, 1'b1}, '0, '0}},
        '{KIND_WORD, 8'hFF, 1'b1, 2'd1, '{'{1'b0, 4'd7, 1'b1}, '0, '0}},
        '{KIND_CHAR, "E",   1'b1, 2'd3,
          '{'{1'b1, 4'd1, 1'b0}, '{1'b0, 4'd1, 1'b0}, '{1'b0, 4'd3, 1'b1}}},
        '{KIND_CHAR, "T",   1'b1, 2'd3,
          '{'{1'b1, 4'd3, 1'b0}, '{1'b0, 4'd1, 1'b0}, '{1'b0, 4'd3, 1'b1}}},
        '{KIND_CHAR, "e",   1'b1, 2'd3,
          '{'{1'b1, 4'd1, 1'b0}, '{1'b0, 4'd1, 1'b0}, '{1'b0, 4'd3, 1'b1}}},
        '{KIND_CHAR, 8'h00, 1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h09, 1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h0A, 1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h0F, 1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h10, 1'b1, 2'd0, '0},
        '{KIND_CHAR, 8'h2F, 1'b1, 2'd0, '0},
        '{KIND_CHAR, "0",   1'b0, 2'd0, '0},
        '{KIND_CHAR, "9",   1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h3A, 1'b1, 2'd0, '0},
        '{KIND_CHAR, 8'h40, 1'b1, 2'd0, '0},
        '{KIND_CHAR, "A",   1'b0, 2'd0, '0},
        '{KIND_CHAR, "Z",   1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h5B, 1'b1, 2'd0, '0},
        '{KIND_CHAR, 8'h60, 1'b1, 2'd0, '0},
        '{KIND_CHAR, "a",   1'b0, 2'd0, '0},
        '{KIND_CHAR, "z",   1'b0, 2'd0, '0},
        '{KIND_CHAR, 8'h7B, 1'b1, 2'd0, '0},
        '{KIND_CHAR, 8'h80, 1'b1, 2'd0, '0},
        '{KIND_CHAR, 8'hFF, 1'b1, 2'd0, '0}
    };

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [MCK_CODE_W-1:0]       s_tdata   = '0;     // [7:0] char_code
    logic                        s_tuser   = 1'b0;   // [0] kind
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [MCK_OUT_DATA_W-1:0]   m_tdata;            // [0] key_on, [4:1] duration
    logic                        m_tlast;
    logic                        cfg_wr_en = 1'b0;
    logic [MCK_CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [MCK_DUR_W-1:0]        cfg_wdata = '0;

    // Model copy of the timing registers, at reset values
    logic [MCK_DUR_W-1:0] dit_len = 4'd1;
    logic [MCK_DUR_W-1:0] dah_len = 4'd3;
    logic [MCK_DUR_W-1:0] gap_len = 4'd1;
    logic [MCK_DUR_W-1:0] chr_len = 4'd3;
    logic [MCK_DUR_W-1:0] wsp_len = 4'd7;

    interval_t pending_intervals [$];
    int        err_count    = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;

    morse_character_keyer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queue the intervals an item yields; returns how many
    function automatic int predict_intervals(input logic kind,
                                             input logic [MCK_CODE_W-1:0] code);
        int         sym;
        int         n_elem;
        int         count;
        logic [5:0] symbol;
        if (kind == KIND_WORD) begin
            pending_intervals.push_back(interval_t'{1'b0, wsp_len, 1'b1});
            return 1;
        end
        // raw digits and A-F, ASCII digits, then letters of either case
        if (code <= 8'h0F)
            sym = int'(code);
        else if (code >= "0" && code <= "9")
            sym = int'(code - "0");
        else if (code >= "A" && code <= "Z")
            sym = int'(code - "A") + 10;
        else if (code >= "a" && code <= "z")
            sym = int'(code - "a") + 10;
        else
            return 0;
        symbol = MORSE_SYMBOLS[sym];
        n_elem = 0;
        for (int b = 1; b <= 5; b++)
            if (symbol[b]) n_elem = b;
        count = 0;
        for (int i = n_elem - 1; i >= 0; i--) begin
            pending_intervals.push_back(interval_t'{1'b1, symbol[i] ? dah_len : dit_len, 1'b0});
            pending_intervals.push_back(interval_t'{1'b0, gap_len, 1'b0});
            count += 2;
        end
        pending_intervals.push_back(interval_t'{1'b0, chr_len, 1'b1});
        return count + 1;
    endfunction

    // Present one beat on the input stream and wait for it to be taken
    task automatic send_item(input logic kind, input logic [MCK_CODE_W-1:0] code);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random items; only those that yield intervals count toward n_items
    task automatic run_random(input int n_items);
        int                    produced;
        int                    roll;
        logic                  kind;
        logic [MCK_CODE_W-1:0] code;
        produced = 0;
        while (produced < n_items) begin
            roll = $urandom_range(99);
            kind = KIND_CHAR;
            if (roll < 12) begin
                kind = KIND_WORD;
                code = MCK_CODE_W'($urandom_range(255));
            end else if (roll < 27) begin
                code = MCK_CODE_W'($urandom_range(255));
            end else begin
                case ($urandom_range(3))
                    0: code = MCK_CODE_W'($urandom_range(15));
                    1: code = MCK_CODE_W'($urandom_range("9", "0"));
                    2: code = MCK_CODE_W'($urandom_range("Z", "A"));
                    default: code = MCK_CODE_W'($urandom_range("z", "a"));
                endcase
            end
            send_item(kind, code);
            if (predict_intervals(kind, code) != 0) produced++;
        end
    endtask

    // Stop sending, collect every queued interval, then let the block go idle
    task automatic settle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_intervals.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_intervals.size() != 0) begin
            $error("%0d intervals never arrived", pending_intervals.size());
            err_count++;
            pending_intervals.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all five timing registers, optionally poking unused indexes too
    task automatic program_timing(input logic [MCK_DUR_W-1:0] dit, dah, gap, chr, wsp,
                                  input bit poke_stray);
        cfg_idx_t                  order [5];
        logic [MCK_DUR_W-1:0]      vals [5];
        logic [MCK_CFG_ADDR_W-1:0] stray [2];
        order = '{REG_DIT, REG_DAH, REG_ELEM_GAP, REG_CHAR_SPACE, REG_WORD_SPACE};
        vals  = '{dit, dah, gap, chr, wsp};
        stray = '{STRAY_IDX_A, STRAY_IDX_B};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (order[i])
                REG_DIT:        dit_len = vals[i];
                REG_DAH:        dah_len = vals[i];
                REG_ELEM_GAP:   gap_len = vals[i];
                REG_CHAR_SPACE: chr_len = vals[i];
                REG_WORD_SPACE: wsp_len = vals[i];
                default: ;
            endcase
        end
        // distinctive value so an aliased decode shows up in some duration
        if (poke_stray) begin
            for (int i = 0; i < 2; i++) begin
                cfg_wr_en <= 1'b1;
                cfg_addr  <= stray[i];
                cfg_wdata <= 4'hA;
                @(posedge aclk);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Output side: random back-pressure and interval checks
    always @(posedge aclk) begin
        interval_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_intervals.size() == 0) begin
                $error("unexpected interval: key_on %0b duration %0d last %0b",
                       m_tdata[0], m_tdata[4:1], m_tlast);
                err_count++;
            end else begin
                want = pending_intervals.pop_front();
                if (m_tdata[0] !== want.key_on) begin
                    $error("key_on: expected %0b, got %0b", want.key_on, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[4:1] !== want.duration) begin
                    $error("duration: expected %0d, got %0d", want.duration, m_tdata[4:1]);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    err_count++;
                end
                if (m_tdata[7:5] !== 3'b000) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[7:5]);
                    err_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles less than the receiver, reset timing first
        src_idle_pct = 28;
        snk_idle_pct = 61;
        foreach (DIRECTED_ROWS[i]) begin
            send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].code);
            if (DIRECTED_ROWS[i].typed) begin
                for (int k = 0; k < DIRECTED_ROWS[i].n_typed; k++)
                    pending_intervals.push_back(DIRECTED_ROWS[i].typed_iv[k]);
            end else begin
                void'(predict_intervals(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].code));
            end
        end
        run_random(16);
        settle();

        // Longest durations everywhere
        program_timing(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 1'b0);
        run_random(16);
        settle();

        // Roles swapped; shortest nonzero durations, unused indexes poked
        src_idle_pct = 61;
        snk_idle_pct = 28;
        program_timing(4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 1'b1);
        run_random(29);
        settle();

        // No idling; zero dit, gap and word-space durations, then arbitrary timing
        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_timing(4'd0, 4'd15, 4'd0, MCK_DUR_W'($urandom_range(15, 1)), 4'd0, 1'b0);
        run_random(12);
        settle();
        program_timing(MCK_DUR_W'($urandom_range(15)), MCK_DUR_W'($urandom_range(15)),
                       MCK_DUR_W'($urandom_range(15)), MCK_DUR_W'($urandom_range(15)),
                       MCK_DUR_W'($urandom_range(15)), 1'b1);
        run_random(22);
        settle();

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
